// File: hw/rtl/bcmb_pkg.sv
// ----------------------------------------------------------------------------
// bcmb_pkg
// shared types and codes of the battery cell monitor and balancer
// ----------------------------------------------------------------------------
package bcmb_pkg;

  localparam int unsigned NumCells = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_VOLT_MIN  = 3'd0,
    CFG_VOLT_MAX  = 3'd1,
    CFG_TEMP_MIN  = 3'd2,
    CFG_TEMP_MAX  = 3'd3,
    CFG_CHG_LIM   = 3'd4,
    CFG_DSG_LIM   = 3'd5,
    CFG_BAL_START = 3'd6,
    CFG_BAL_STOP  = 3'd7
  } cfg_reg_e;

  // latched fault codes
  typedef enum logic [1:0] {
    FAULT_CLEAR   = 2'd0,
    FAULT_VOLTAGE = 2'd1,
    FAULT_THERMAL = 2'd2,
    FAULT_CURRENT = 2'd3
  } fault_code_e;

  // one scan
  typedef struct packed {
    logic [11:0]        cell1_adc;
    logic [11:0]        cell2_adc;
    logic [11:0]        cell3_adc;
    logic signed [7:0]  cell1_temp;
    logic signed [7:0]  cell2_temp;
    logic signed [7:0]  cell3_temp;
    logic [11:0]        current_adc;
    logic               button_level;
  } in_item_t;

  // one status report
  typedef struct packed {
    logic               relay_closed;
    logic [2:0]         balance_mask;
    logic [1:0]         fault_code;
    logic [1:0]         fault_cell;
    logic signed [15:0] fault_value;
    logic               halted;
    logic [12:0]        min_cell_voltage;
    logic signed [15:0] pack_current;
  } out_item_t;

  // configuration write
  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_item_t;

endpackage

// File: hw/rtl/bcmb_in_if.sv
// ----------------------------------------------------------------------------
// bcmb_in_if
// scan channel, valid/ready with one scan per item
// ----------------------------------------------------------------------------
interface bcmb_in_if;
  import bcmb_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/bcmb_out_if.sv
// ----------------------------------------------------------------------------
// bcmb_out_if
// status channel, valid/ready with one report per item
// ----------------------------------------------------------------------------
interface bcmb_out_if;
  import bcmb_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/bcmb_cfg_if.sv
// ----------------------------------------------------------------------------
// bcmb_cfg_if
// configuration write channel, register index and write data
// ----------------------------------------------------------------------------
interface bcmb_cfg_if;
  import bcmb_pkg::*;

  logic      valid;
  logic      ready;
  cfg_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/battery_cell_monitor_balancer_core.sv
// ----------------------------------------------------------------------------
// battery_cell_monitor_balancer_core
// three-cell protection with fault latch, power-off and passive balancing
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake            payload
//   in_i     in   valid/ready          one scan: adc readings, temps, button
//   out_o    out  valid/ready          relay, balance mask, fault, min, current
//   cfg_i    in   valid/ready (ready=1) register index and write data
//
// one item per cycle unless out_o stalls; scans pass stage one and out_q
// stage one converts the raw readings (a constant multiply per cell),
// stage two runs the fault checks, balancing and the state update
// reset clears the pipeline valids, halt, fault latch, balance bits and
// loads the default thresholds; only reset ends a halt
// a stall on out_o holds stage two and drops in_i.ready once stage one is full
//
module battery_cell_monitor_balancer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  bcmb_in_if.sink    in_i,
  bcmb_out_if.source out_o,
  bcmb_cfg_if.sink   cfg_i
);
  import bcmb_pkg::*;

  // default thresholds
  localparam logic [15:0]        VoltMinRst  = 16'd3277;
  localparam logic [15:0]        VoltMaxRst  = 16'd4403;
  localparam logic signed [7:0]  TempMinRst  = 8'sd0;
  localparam logic signed [7:0]  TempMaxRst  = 8'sd60;
  localparam logic [14:0]        ChgLimRst   = 15'd25600;
  localparam logic [14:0]        DsgLimRst   = 15'd25600;
  localparam logic [15:0]        BalStartRst = 16'd204;
  localparam logic [15:0]        BalStopRst  = 16'd52;

  // reciprocal of 5 scaled by 2^18, exact for quotients of values below 2^18
  localparam logic [15:0] RecipFive   = 16'd52429;
  localparam logic signed [16:0] AmpsOffset = 17'sd25600;

  // volts*1024 = floor(raw*33/40)*2, with /40 as >>3 then times 1/5
  function automatic logic [12:0] cell_volts(input logic [11:0] raw);
    logic [17:0] x;
    logic [14:0] y;
    logic [31:0] p;
    logic [11:0] q;
    x = 18'({raw, 5'b0}) + 18'(raw);
    y = x[17:3];
    p = 32'(y) * 32'(RecipFive);
    q = p[29:18];
    return {q, 1'b0};
  endfunction

  // amps*1024 = floor(raw*25/2) - 25600
  function automatic logic signed [15:0] pack_amps(input logic [11:0] raw);
    logic [16:0]        x;
    logic [15:0]        h;
    logic signed [16:0] s;
    x = 17'({raw, 4'b0}) + 17'({raw, 3'b0}) + 17'(raw);
    h = x[16:1];
    s = $signed({1'b0, h}) - AmpsOffset;
    return s[15:0];
  endfunction

  // configuration registers
  logic [15:0]       volt_min_q, volt_max_q, bal_start_q, bal_stop_q;
  logic signed [7:0] temp_min_q, temp_max_q;
  logic [14:0]       chg_lim_q, dsg_lim_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volt_min_q  <= VoltMinRst;
      volt_max_q  <= VoltMaxRst;
      temp_min_q  <= TempMinRst;
      temp_max_q  <= TempMaxRst;
      chg_lim_q   <= ChgLimRst;
      dsg_lim_q   <= DsgLimRst;
      bal_start_q <= BalStartRst;
      bal_stop_q  <= BalStopRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.data.index))
        CFG_VOLT_MIN:  volt_min_q  <= cfg_i.data.data;
        CFG_VOLT_MAX:  volt_max_q  <= cfg_i.data.data;
        CFG_TEMP_MIN:  temp_min_q  <= $signed(cfg_i.data.data[7:0]);
        CFG_TEMP_MAX:  temp_max_q  <= $signed(cfg_i.data.data[7:0]);
        CFG_CHG_LIM:   chg_lim_q   <= cfg_i.data.data[14:0];
        CFG_DSG_LIM:   dsg_lim_q   <= cfg_i.data.data[14:0];
        CFG_BAL_START: bal_start_q <= cfg_i.data.data;
        CFG_BAL_STOP:  bal_stop_q  <= cfg_i.data.data;
        default: ;
      endcase
    end
  end

  // pipeline flow: stage two moves whenever it holds a scan and the output
  // register is free or being emptied in this cycle
  logic s1_valid_q, out_valid_q;
  logic advance;

  assign advance     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || advance;
  assign out_o.valid = out_valid_q;

  // stage one: converted scan
  logic [12:0]        s1_volt_q [NumCells];
  logic signed [7:0]  s1_temp_q [NumCells];
  logic signed [15:0] s1_amps_q;
  logic               s1_button_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_volt_q[0] <= cell_volts(in_i.data.cell1_adc);
      s1_volt_q[1] <= cell_volts(in_i.data.cell2_adc);
      s1_volt_q[2] <= cell_volts(in_i.data.cell3_adc);
      s1_temp_q[0] <= in_i.data.cell1_temp;
      s1_temp_q[1] <= in_i.data.cell2_temp;
      s1_temp_q[2] <= in_i.data.cell3_temp;
      s1_amps_q    <= pack_amps(in_i.data.current_adc);
      s1_button_q  <= in_i.data.button_level;
    end
  end

  // protection state
  logic               halt_q, halt_d;
  logic [2:0]         bal_q, bal_d;
  logic [1:0]         fcode_q, fcode_d;
  logic [1:0]         fcell_q, fcell_d;
  logic signed [15:0] fvalue_q, fvalue_d;

  // stage two: checks and state update
  logic [12:0]        vmin;
  logic [12:0]        gap [NumCells];
  logic               cell_trip [NumCells];
  logic [1:0]         cell_code [NumCells];
  logic signed [15:0] cell_val  [NumCells];
  logic               any_trip;
  logic [1:0]         trip_code;
  logic [1:0]         trip_cell;
  logic signed [15:0] trip_val;
  logic signed [16:0] amps_ext;
  logic signed [16:0] chg_neg;
  logic signed [16:0] dsg_pos;

  always_comb begin
    // lowest cell of this scan
    vmin = s1_volt_q[0];
    for (int i = 1; i < NumCells; i++) begin
      if (s1_volt_q[i] < vmin) begin
        vmin = s1_volt_q[i];
      end
    end

    // per-cell check: under-voltage, over-voltage, under-temp, over-temp
    for (int i = 0; i < NumCells; i++) begin
      gap[i]       = s1_volt_q[i] - vmin;
      cell_trip[i] = 1'b1;
      cell_code[i] = FAULT_VOLTAGE;
      cell_val[i]  = $signed({3'b0, s1_volt_q[i]});
      priority if ({3'b0, s1_volt_q[i]} < volt_min_q) begin
        cell_code[i] = FAULT_VOLTAGE;
      end else if ({3'b0, s1_volt_q[i]} > volt_max_q) begin
        cell_code[i] = FAULT_VOLTAGE;
      end else if (s1_temp_q[i] < temp_min_q) begin
        cell_code[i] = FAULT_THERMAL;
        cell_val[i]  = 16'(s1_temp_q[i]);
      end else if (s1_temp_q[i] > temp_max_q) begin
        cell_code[i] = FAULT_THERMAL;
        cell_val[i]  = 16'(s1_temp_q[i]);
      end else begin
        cell_trip[i] = 1'b0;
      end
    end

    // pack current window
    amps_ext = 17'(s1_amps_q);
    chg_neg  = -$signed({2'b0, chg_lim_q});
    dsg_pos  = $signed({2'b0, dsg_lim_q});

    // lowest cell index wins, current comes last
    any_trip  = 1'b1;
    trip_code = FAULT_CURRENT;
    trip_cell = 2'd0;
    trip_val  = s1_amps_q;
    priority if (cell_trip[0]) begin
      trip_code = cell_code[0];
      trip_cell = 2'd0;
      trip_val  = cell_val[0];
    end else if (cell_trip[1]) begin
      trip_code = cell_code[1];
      trip_cell = 2'd1;
      trip_val  = cell_val[1];
    end else if (cell_trip[2]) begin
      trip_code = cell_code[2];
      trip_cell = 2'd2;
      trip_val  = cell_val[2];
    end else if (amps_ext < chg_neg || amps_ext > dsg_pos) begin
      trip_code = FAULT_CURRENT;
    end else begin
      any_trip = 1'b0;
    end

    // next state: once halted, everything holds
    halt_d   = halt_q;
    bal_d    = bal_q;
    fcode_d  = fcode_q;
    fcell_d  = fcell_q;
    fvalue_d = fvalue_q;
    if (!halt_q) begin
      if (any_trip) begin
        halt_d   = 1'b1;
        fcode_d  = trip_code;
        fcell_d  = trip_cell;
        fvalue_d = trip_val;
      end else begin
        // hysteresis: stop wins when both thresholds hit
        for (int i = 0; i < NumCells; i++) begin
          if ({3'b0, gap[i]} > bal_start_q) begin
            bal_d[i] = 1'b1;
          end
          if ({3'b0, gap[i]} < bal_stop_q) begin
            bal_d[i] = 1'b0;
          end
        end
        // button released means power off
        if (!s1_button_q) begin
          halt_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halt_q   <= 1'b0;
      bal_q    <= 3'b0;
      fcode_q  <= FAULT_CLEAR;
      fcell_q  <= 2'd0;
      fvalue_q <= 16'sd0;
    end else if (advance) begin
      halt_q   <= halt_d;
      bal_q    <= bal_d;
      fcode_q  <= fcode_d;
      fcell_q  <= fcell_d;
      fvalue_q <= fvalue_d;
    end
  end

  // output register
  out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.relay_closed     <= !halt_d;
      out_q.balance_mask     <= bal_d;
      out_q.fault_code       <= fcode_d;
      out_q.fault_cell       <= fcell_d;
      out_q.fault_value      <= fvalue_d;
      out_q.halted           <= halt_d;
      out_q.min_cell_voltage <= vmin;
      out_q.pack_current     <= s1_amps_q;
    end
  end

  assign out_o.data = out_q;

endmodule
